[hw/rtl/wpe_pkg.sv]
`default_nettype none

package wpe_pkg;

    localparam int unsigned C_COLOR_W   = 8;
    localparam int unsigned C_PIXEL_W   = 3 * C_COLOR_W;
    localparam int unsigned C_NS_W      = 16;
    localparam int unsigned C_US_W      = 10;
    localparam int unsigned C_DUR_W     = 20;
    localparam int unsigned C_CFG_IDX_W = 3;
    localparam int unsigned C_CFG_DAT_W = 16;
    localparam int unsigned C_STEP_W    = 6;

    // Segment sequence of one pixel: optional lead-in, 48 bit halves, optional latch
    localparam logic [C_STEP_W-1:0] C_STEP_LEAD      = 6'd0;
    localparam logic [C_STEP_W-1:0] C_STEP_FIRST_BIT = 6'd1;
    localparam logic [C_STEP_W-1:0] C_STEP_LAST_BIT  = 6'd48;
    localparam logic [C_STEP_W-1:0] C_STEP_LATCH     = 6'd49;

    localparam logic [C_DUR_W-1:0] C_NS_PER_US = 20'd1000;

    localparam logic [C_NS_W-1:0] C_RST_ONE_HIGH  = 16'd800;
    localparam logic [C_NS_W-1:0] C_RST_ONE_LOW   = 16'd450;
    localparam logic [C_NS_W-1:0] C_RST_ZERO_HIGH = 16'd400;
    localparam logic [C_NS_W-1:0] C_RST_ZERO_LOW  = 16'd850;
    localparam logic [C_US_W-1:0] C_RST_LATCH     = 10'd80;
    localparam logic [C_US_W-1:0] C_RST_LEAD_IN   = 10'd0;
    localparam logic [C_US_W-1:0] C_RST_IDLE      = 10'd0;

    typedef enum logic [1:0] {
        K_LEAD  = 2'd0,
        K_HIGH  = 2'd1,
        K_LOW   = 2'd2,
        K_LATCH = 2'd3
    } t_kind;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        R_ONE_HIGH  = 3'd0,
        R_ONE_LOW   = 3'd1,
        R_ZERO_HIGH = 3'd2,
        R_ZERO_LOW  = 3'd3,
        R_LATCH     = 3'd4,
        R_LEAD_IN   = 3'd5,
        R_IDLE      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [C_NS_W-1:0] one_high_ns;
        logic [C_NS_W-1:0] one_low_ns;
        logic [C_NS_W-1:0] zero_high_ns;
        logic [C_NS_W-1:0] zero_low_ns;
        logic [C_US_W-1:0] latch_reset_us;
        logic [C_US_W-1:0] lead_in_us;
        logic [C_US_W-1:0] idle_before_us;
    } t_cfg;

    typedef struct packed {
        logic               level;
        logic [C_DUR_W-1:0] duration_ns;
        t_kind              kind;
        logic               last;
    } t_seg;

endpackage

`default_nettype wire

[hw/rtl/wpe_seg_gen.sv]
`default_nettype none

module wpe_seg_gen (
    input  wire logic [wpe_pkg::C_STEP_W-1:0]  i_step,
    input  wire logic [wpe_pkg::C_PIXEL_W-1:0] i_pixel,
    input  wire logic                          i_final,
    input  wire wpe_pkg::t_cfg                 i_cfg,
    output wpe_pkg::t_seg                      o_seg
);

    logic [wpe_pkg::C_STEP_W-1:0] bit_step;
    logic [wpe_pkg::C_STEP_W-2:0] bit_num;
    logic [wpe_pkg::C_STEP_W-2:0] bit_idx;
    logic                         bit_val;
    logic [wpe_pkg::C_US_W-1:0]   lead_us;

    always_comb begin
        bit_step = i_step - wpe_pkg::C_STEP_FIRST_BIT;
        bit_num  = bit_step[wpe_pkg::C_STEP_W-1:1];
        // pixel word is {green, red, blue}; bit 0 of the sequence is its MSB
        bit_idx  = (wpe_pkg::C_STEP_W-1)'(wpe_pkg::C_PIXEL_W - 1) - bit_num;
        bit_val  = i_pixel[bit_idx];
        lead_us  = (i_cfg.lead_in_us != '0) ? i_cfg.lead_in_us : i_cfg.idle_before_us;

        o_seg = '0;
        if (i_step == wpe_pkg::C_STEP_LEAD) begin
            o_seg.level       = 1'b0;
            o_seg.kind        = wpe_pkg::K_LEAD;
            o_seg.duration_ns = wpe_pkg::C_DUR_W'(lead_us) * wpe_pkg::C_NS_PER_US;
        end else if (i_step == wpe_pkg::C_STEP_LATCH) begin
            o_seg.level       = 1'b0;
            o_seg.kind        = wpe_pkg::K_LATCH;
            o_seg.duration_ns = wpe_pkg::C_DUR_W'(i_cfg.latch_reset_us)
                                * wpe_pkg::C_NS_PER_US;
        end else if (!bit_step[0]) begin
            o_seg.level       = 1'b1;
            o_seg.kind        = wpe_pkg::K_HIGH;
            o_seg.duration_ns = bit_val ? wpe_pkg::C_DUR_W'(i_cfg.one_high_ns)
                                        : wpe_pkg::C_DUR_W'(i_cfg.zero_high_ns);
        end else begin
            o_seg.level       = 1'b0;
            o_seg.kind        = wpe_pkg::K_LOW;
            o_seg.duration_ns = bit_val ? wpe_pkg::C_DUR_W'(i_cfg.one_low_ns)
                                        : wpe_pkg::C_DUR_W'(i_cfg.zero_low_ns);
        end
        o_seg.last = i_final ? (i_step == wpe_pkg::C_STEP_LATCH)
                             : (i_step == wpe_pkg::C_STEP_LAST_BIT);
    end

endmodule

`default_nettype wire

[hw/rtl/ws2812_pixel_pulse_encoder.sv]
// WS2812 pixel pulse encoder.
// Input channel (i_in_valid / o_in_stall): one beat per pixel (all three colours), with
// frame_first / frame_final flags. Output channel (o_out_valid / i_out_stall):
// one beat per line segment (level, duration in ns, kind, run_last).
// Each pixel yields 48 bit segments (green, red, blue, MSB first, high then
// low), plus a lead-in segment on a frame's first pixel when lead_in_us or
// idle_before_us is nonzero, plus a latch segment on a frame's last pixel.
// A pixel moves from the holding register into the working register, and
// its segments leave through the single output register, one segment per
// cycle while the receiver does not stall: 48 to 50 per pixel. A one-pixel
// holding register takes the next pixel while the current one is sent, so
// consecutive pixels produce segments with no gap. The user must write the
// configuration (i_cfg_valid / o_cfg_ready, always ready) only while no
// pixel is in flight; the block does not enforce this. Reset restores the
// register defaults and empties all stages. On a receiver stall the output
// beat holds and the sequencer waits; a full holding register stalls input.
`default_nettype none

module ws2812_pixel_pulse_encoder (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // pixel input
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [wpe_pkg::C_COLOR_W-1:0]    i_red,
    input  wire logic [wpe_pkg::C_COLOR_W-1:0]    i_green,
    input  wire logic [wpe_pkg::C_COLOR_W-1:0]    i_blue,
    input  wire logic                             i_frame_first,
    input  wire logic                             i_frame_final,
    // segment output
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_line_level,
    output logic [wpe_pkg::C_DUR_W-1:0]           o_duration_ns,
    output logic [1:0]                            o_segment_kind,
    output logic                                  o_run_last,
    // configuration write
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [wpe_pkg::C_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wpe_pkg::C_CFG_DAT_W-1:0]  i_cfg_data
);

    wpe_pkg::t_cfg                r_cfg;

    logic                         r_hold_vld;
    logic [wpe_pkg::C_PIXEL_W-1:0] r_hold_pixel;
    logic                         r_hold_first;
    logic                         r_hold_final;

    logic                         r_work_vld;
    logic [wpe_pkg::C_PIXEL_W-1:0] r_work_pixel;
    logic                         r_work_final;
    logic [wpe_pkg::C_STEP_W-1:0] r_step;

    logic                         r_out_vld;
    wpe_pkg::t_seg                r_out;

    logic                         n_hold_vld;
    logic                         n_work_vld;
    logic [wpe_pkg::C_STEP_W-1:0] n_step;
    logic                         n_out_vld;

    wpe_pkg::t_seg                seg;
    logic                         out_free;
    logic                         emit;
    logic                         work_done;
    logic                         load_work;
    logic                         in_accept;
    logic                         has_lead;
    logic [wpe_pkg::C_STEP_W-1:0] start_step;

    wpe_seg_gen u_seg_gen (
        .i_step  (r_step),
        .i_pixel (r_work_pixel),
        .i_final (r_work_final),
        .i_cfg   (r_cfg),
        .o_seg   (seg)
    );

    always_comb begin
        out_free   = !r_out_vld || !i_out_stall;
        emit       = r_work_vld && out_free;
        work_done  = emit && seg.last;
        load_work  = r_hold_vld && (!r_work_vld || work_done);
        o_in_stall = r_hold_vld && !load_work;
        in_accept  = i_in_valid && !o_in_stall;

        has_lead   = r_hold_first
                     && (r_cfg.lead_in_us != '0 || r_cfg.idle_before_us != '0);
        start_step = has_lead ? wpe_pkg::C_STEP_LEAD : wpe_pkg::C_STEP_FIRST_BIT;

        n_hold_vld = in_accept ? 1'b1 : (load_work ? 1'b0 : r_hold_vld);
        n_work_vld = load_work ? 1'b1 : (work_done ? 1'b0 : r_work_vld);
        n_step     = load_work ? start_step
                               : (emit ? r_step + wpe_pkg::C_STEP_W'(1) : r_step);
        n_out_vld  = out_free ? emit : r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_work_vld <= 1'b0;
            r_step     <= wpe_pkg::C_STEP_FIRST_BIT;
            r_out_vld  <= 1'b0;
        end else begin
            r_hold_vld <= n_hold_vld;
            r_work_vld <= n_work_vld;
            r_step     <= n_step;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_hold_pixel <= {i_green, i_red, i_blue};
            r_hold_first <= i_frame_first;
            r_hold_final <= i_frame_final;
        end
        if (load_work) begin
            r_work_pixel <= r_hold_pixel;
            r_work_final <= r_hold_final;
        end
        if (emit) begin
            r_out <= seg;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high_ns    <= wpe_pkg::C_RST_ONE_HIGH;
            r_cfg.one_low_ns     <= wpe_pkg::C_RST_ONE_LOW;
            r_cfg.zero_high_ns   <= wpe_pkg::C_RST_ZERO_HIGH;
            r_cfg.zero_low_ns    <= wpe_pkg::C_RST_ZERO_LOW;
            r_cfg.latch_reset_us <= wpe_pkg::C_RST_LATCH;
            r_cfg.lead_in_us     <= wpe_pkg::C_RST_LEAD_IN;
            r_cfg.idle_before_us <= wpe_pkg::C_RST_IDLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wpe_pkg::R_ONE_HIGH:  r_cfg.one_high_ns    <= i_cfg_data;
                wpe_pkg::R_ONE_LOW:   r_cfg.one_low_ns     <= i_cfg_data;
                wpe_pkg::R_ZERO_HIGH: r_cfg.zero_high_ns   <= i_cfg_data;
                wpe_pkg::R_ZERO_LOW:  r_cfg.zero_low_ns    <= i_cfg_data;
                wpe_pkg::R_LATCH:     r_cfg.latch_reset_us <= i_cfg_data[wpe_pkg::C_US_W-1:0];
                wpe_pkg::R_LEAD_IN:   r_cfg.lead_in_us     <= i_cfg_data[wpe_pkg::C_US_W-1:0];
                wpe_pkg::R_IDLE:      r_cfg.idle_before_us <= i_cfg_data[wpe_pkg::C_US_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_vld;
    assign o_line_level   = r_out.level;
    assign o_duration_ns  = r_out.duration_ns;
    assign o_segment_kind = r_out.kind;
    assign o_run_last     = r_out.last;

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_work_vld |-> r_step <= wpe_pkg::C_STEP_LATCH)
        else $error("segment step out of range");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_run_last) |->
            (r_out.kind == wpe_pkg::K_LOW || r_out.kind == wpe_pkg::K_LATCH))
        else $error("run_last on a segment that cannot end a pixel");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_hold_vld)
        else $error("input stalled with empty holding register");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_vld && !r_work_vld) |=> r_work_vld)
        else $error("held pixel not moved into an idle sequencer");
`endif

endmodule

`default_nettype wire
